@@ design/gps_pkg.sv @@
// Shared types and constants of the gait phase scheduler.
`default_nettype none

package gps_pkg;

    localparam int LEG_SLOTS   = 4;
    localparam int LEG_IDX_W   = 2;
    localparam int LANE_W      = 16;
    localparam int STEP_W      = 16;
    localparam int CLOCK_W     = 32;
    localparam int DVD_W       = CLOCK_W + 1;
    localparam int PHASE_W     = 16;
    localparam int CNT_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int OUT_BITS    = LEG_SLOTS + LEG_SLOTS * PHASE_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_PERIODS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSETS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTIES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE   = 2'd3;

    typedef struct packed {
        logic                 load_in;
        logic                 mul_off;
        logic                 mod_init;
        logic                 mod_step;
        logic                 mul_edge;
        logic                 select_den;
        logic                 frac_step;
        logic                 store_leg;
        logic                 load_out;
        logic [LEG_IDX_W-1:0] leg;
    } gps_cmd_t;

endpackage

`default_nettype wire

@@ design/gait_phase_scheduler.sv @@
// Each accepted item is worked through the legs one after another by the shared remainder
// and fraction dividers, which take one bit per cycle; a leg with a zero period skips both.
// The block takes no new item before it is through with the last; a new item is taken
// while the previous result waits in the output register, but a stalled output holds the
// controller in its done state until the output register is free.
// Reset clears the gait clock, all configuration registers and the control state.
`default_nettype none

module gait_phase_scheduler #(
    parameter int LEG_COUNT  = 4,
    parameter int PHASE_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [gps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // step_time
    input  wire logic [gps_pkg::STEP_W-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // leg0_swing, leg1_swing, leg2_swing, leg3_swing,
    // leg0_phase, leg1_phase, leg2_phase, leg3_phase, zero fill
    output logic [gps_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

    gps_pkg::gps_cmd_t cmd;
    logic              per_zero;

    gps_ctrl #(
        .LEG_COUNT  (LEG_COUNT),
        .PHASE_BITS (PHASE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .per_zero  (per_zero),
        .cmd       (cmd)
    );

    gps_datapath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_time (s_axis_tdata),
        .cmd       (cmd),
        .per_zero  (per_zero),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ design/gps_ctrl.sv @@
// Controller state machine of the gait phase scheduler.
`default_nettype none

module gps_ctrl #(
    parameter int LEG_COUNT  = 4,
    parameter int PHASE_BITS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire logic      per_zero,
    output gps_pkg::gps_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OFF   = 4'd1;
    localparam logic [3:0] S_MODI  = 4'd2;
    localparam logic [3:0] S_MOD   = 4'd3;
    localparam logic [3:0] S_EDGE  = 4'd4;
    localparam logic [3:0] S_DEN   = 4'd5;
    localparam logic [3:0] S_FRAC  = 4'd6;
    localparam logic [3:0] S_STORE = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [gps_pkg::CNT_W-1:0] MOD_LAST =
        gps_pkg::CNT_W'(gps_pkg::DVD_W - 1);
    localparam logic [gps_pkg::CNT_W-1:0] FRAC_LAST =
        gps_pkg::CNT_W'(PHASE_BITS - 1);
    localparam logic [gps_pkg::LEG_IDX_W-1:0] LEG_LAST =
        gps_pkg::LEG_IDX_W'(LEG_COUNT - 1);

    logic [3:0]                     state_reg, state_next;
    logic [gps_pkg::LEG_IDX_W-1:0]  leg_reg, leg_next;
    logic [gps_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        leg_next       = leg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.leg        = leg_reg;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    leg_next    = '0;
                    state_next  = S_OFF;
                end
            end
            S_OFF:
            begin
                cmd.mul_off = 1'b1;
                state_next  = per_zero ? S_STORE : S_MODI;
            end
            S_MODI:
            begin
                cmd.mod_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + gps_pkg::CNT_W'(1);
                if (cnt_reg == MOD_LAST)
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                cmd.mul_edge = 1'b1;
                state_next   = S_DEN;
            end
            S_DEN:
            begin
                cmd.select_den = 1'b1;
                cnt_next       = '0;
                state_next     = S_FRAC;
            end
            S_FRAC:
            begin
                cmd.frac_step = 1'b1;
                cnt_next      = cnt_reg + gps_pkg::CNT_W'(1);
                if (cnt_reg == FRAC_LAST)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store_leg = 1'b1;
                if (leg_reg == LEG_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    leg_next   = leg_reg + gps_pkg::LEG_IDX_W'(1);
                    state_next = S_OFF;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            leg_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            leg_reg       <= leg_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ design/gps_datapath.sv @@
// Datapath of the gait phase scheduler: registers, gait clock, multiplier and dividers.
`default_nettype none

module gps_datapath #(
    parameter int PHASE_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [gps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [gps_pkg::STEP_W-1:0]        step_time,
    input  wire gps_pkg::gps_cmd_t                 cmd,
    output logic                                   per_zero,
    output logic [gps_pkg::OUT_DATA_W-1:0]         out_data
);

    localparam int LW = gps_pkg::LANE_W;
    localparam int CW = gps_pkg::CLOCK_W;
    localparam int NL = gps_pkg::LEG_SLOTS;

    logic [gps_pkg::CFG_DATA_W-1:0] periods_reg;
    logic [gps_pkg::CFG_DATA_W-1:0] offsets_reg;
    logic [gps_pkg::CFG_DATA_W-1:0] duties_reg;
    logic [CW-1:0]                  cycle_len_reg;
    logic [CW-1:0]                  clock_reg;

    logic [CW-1:0]                  prod_reg;
    logic [gps_pkg::DVD_W-1:0]      dvd_reg;
    logic [LW-1:0]                  rem_reg;
    logic [CW-1:0]                  fnum_reg;
    logic [CW-1:0]                  fden_reg;
    logic [PHASE_BITS-1:0]          quot_reg;
    logic                           swing_reg;

    logic [NL-1:0]                  slot_swing_reg;
    logic [PHASE_BITS-1:0]          slot_phase_reg [NL];
    logic [NL-1:0]                  out_swing_reg;
    logic [PHASE_BITS-1:0]          out_phase_reg [NL];

    logic [LW-1:0]                  per;
    logic [LW-1:0]                  off;
    logic [LW-1:0]                  duty;
    logic [CW:0]                    clock_sum;
    logic [LW:0]                    rem_sh;
    logic [CW-1:0]                  t_shift;
    logic                           stance;
    logic [CW-1:0]                  den_prod;
    logic [CW:0]                    frac_sh;

    assign per  = periods_reg[{cmd.leg, 4'b0000} +: LW];
    assign off  = offsets_reg[{cmd.leg, 4'b0000} +: LW];
    assign duty = duties_reg[{cmd.leg, 4'b0000} +: LW];
    assign per_zero = (per == '0);

    assign clock_sum = {1'b0, clock_reg} + (CW + 1)'(step_time);
    assign rem_sh    = {rem_reg, dvd_reg[gps_pkg::DVD_W-1]};
    assign t_shift   = {rem_reg, {LW{1'b0}}};
    assign stance    = (t_shift < prod_reg);
    assign den_prod  = CW'(CW'(per) * CW'((LW + 1)'(1 << LW) - (LW + 1)'(duty)));
    assign frac_sh   = {fnum_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periods_reg   <= '0;
            offsets_reg   <= '0;
            duties_reg    <= '0;
            cycle_len_reg <= '0;
            clock_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    gps_pkg::REG_PERIODS: periods_reg   <= cfg_data;
                    gps_pkg::REG_OFFSETS: offsets_reg   <= cfg_data;
                    gps_pkg::REG_DUTIES:  duties_reg    <= cfg_data;
                    gps_pkg::REG_CYCLE:   cycle_len_reg <= cfg_data[CW-1:0];
                    default:              periods_reg   <= periods_reg;
                endcase
            end
            if (cmd.load_in)
            begin
                if (clock_sum > {1'b0, cycle_len_reg})
                begin
                    clock_reg <= '0;
                end
                else
                begin
                    clock_reg <= clock_sum[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            slot_swing_reg <= '0;
            for (int i = 0; i < NL; i++)
            begin
                slot_phase_reg[i] <= '0;
            end
        end
        if (cmd.mul_off)
        begin
            prod_reg <= CW'(off) * CW'(per);
        end
        if (cmd.mod_init)
        begin
            dvd_reg <= {1'b0, clock_reg} + gps_pkg::DVD_W'(prod_reg[CW-1:LW]);
            rem_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            dvd_reg <= {dvd_reg[gps_pkg::DVD_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, per})
            begin
                rem_reg <= LW'(rem_sh - {1'b0, per});
            end
            else
            begin
                rem_reg <= rem_sh[LW-1:0];
            end
        end
        if (cmd.mul_edge)
        begin
            prod_reg <= CW'(duty) * CW'(per);
        end
        if (cmd.select_den)
        begin
            swing_reg <= !stance;
            quot_reg  <= '0;
            if (stance)
            begin
                fnum_reg <= t_shift;
                fden_reg <= prod_reg;
            end
            else
            begin
                fnum_reg <= t_shift - prod_reg;
                fden_reg <= den_prod;
            end
        end
        if (cmd.frac_step)
        begin
            if (frac_sh >= {1'b0, fden_reg})
            begin
                fnum_reg <= CW'(frac_sh - {1'b0, fden_reg});
                quot_reg <= {quot_reg[PHASE_BITS-2:0], 1'b1};
            end
            else
            begin
                fnum_reg <= frac_sh[CW-1:0];
                quot_reg <= {quot_reg[PHASE_BITS-2:0], 1'b0};
            end
        end
        if (cmd.store_leg)
        begin
            if (per_zero)
            begin
                slot_swing_reg[cmd.leg] <= 1'b0;
                slot_phase_reg[cmd.leg] <= '0;
            end
            else
            begin
                slot_swing_reg[cmd.leg] <= swing_reg;
                slot_phase_reg[cmd.leg] <= quot_reg;
            end
        end
        if (cmd.load_out)
        begin
            out_swing_reg <= slot_swing_reg;
            for (int i = 0; i < NL; i++)
            begin
                out_phase_reg[i] <= slot_phase_reg[i];
            end
        end
    end

    always_comb
    begin
        out_data = '0;
        out_data[NL-1:0] = out_swing_reg;
        for (int i = 0; i < NL; i++)
        begin
            out_data[NL + i * gps_pkg::PHASE_W +: gps_pkg::PHASE_W] =
                gps_pkg::PHASE_W'(out_phase_reg[i]);
        end
    end

endmodule

`default_nettype wire

@@ bench/gait_phase_checker.sv @@
// Checker that predicts every leg report of the gait phase scheduler and compares it.
`timescale 1ns / 1ps

module gait_phase_checker #(
    parameter int LEG_COUNT = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [gps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    // step_time
    input  wire logic [gps_pkg::STEP_W-1:0]     s_axis_tdata,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // leg0_swing, leg1_swing, leg2_swing, leg3_swing,
    // leg0_phase, leg1_phase, leg2_phase, leg3_phase, zero fill
    input  wire logic [gps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  results_seen,
    output int                                  stance_reports,
    output int                                  swing_reports
);

    import gps_pkg::*;

    localparam logic [63:0] PHASE_MAX = (64'd1 << PHASE_W) - 64'd1;

    typedef struct packed {
        logic [LEG_SLOTS-1:0]              swing;
        logic [LEG_SLOTS-1:0][PHASE_W-1:0] phase;
    } leg_report_t;

    leg_report_t           expected_reports[$];
    leg_report_t           want;
    logic [CFG_DATA_W-1:0] periods_r;
    logic [CFG_DATA_W-1:0] offsets_r;
    logic [CFG_DATA_W-1:0] duties_r;
    logic [CLOCK_W-1:0]    cycle_len;
    logic [CLOCK_W-1:0]    gait_time;
    logic                  got_swing;
    logic [PHASE_W-1:0]    got_phase;
    int                    fails;
    int                    results;
    int                    stance_n;
    int                    swing_n;

    function automatic leg_report_t advance_gait(input logic [STEP_W-1:0] step);
        logic [CLOCK_W:0] sum;
        logic [63:0]      per;
        logic [63:0]      off;
        logic [63:0]      duty;
        logic [63:0]      leg_t;
        logic [63:0]      stance_len;
        logic [63:0]      num;
        logic [63:0]      den;
        logic [63:0]      quo;
        leg_report_t      rep;
        sum = {1'b0, gait_time} + (CLOCK_W + 1)'(step);
        if (sum > {1'b0, cycle_len})
            gait_time = '0;
        else
            gait_time = sum[CLOCK_W-1:0];
        rep = '0;
        for (int leg = 0; leg < LEG_SLOTS; leg++)
        begin
            per  = 64'(periods_r[LANE_W*leg +: LANE_W]);
            off  = 64'(offsets_r[LANE_W*leg +: LANE_W]);
            duty = 64'(duties_r[LANE_W*leg +: LANE_W]);
            if (leg < LEG_COUNT && per != 64'd0)
            begin
                leg_t      = (64'(gait_time) + ((off * per) >> LANE_W)) % per;
                stance_len = duty * per;
                if ((leg_t << LANE_W) < stance_len)
                begin
                    quo = (leg_t << (LANE_W + PHASE_W)) / stance_len;
                end
                else
                begin
                    rep.swing[leg] = 1'b1;
                    num = ((leg_t << LANE_W) - stance_len) << PHASE_W;
                    den = per * ((64'd1 << LANE_W) - duty);
                    quo = num / den;
                end
                rep.phase[leg] = (quo > PHASE_MAX) ? PHASE_MAX[PHASE_W-1:0] : quo[PHASE_W-1:0];
            end
        end
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reports.delete();
            periods_r      = '0;
            offsets_r      = '0;
            duties_r       = '0;
            cycle_len      = '0;
            gait_time      = '0;
            fails          = 0;
            results        = 0;
            stance_n       = 0;
            swing_n        = 0;
            fail_count     <= 0;
            pending_count  <= 0;
            results_seen   <= 0;
            stance_reports <= 0;
            swing_reports  <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PERIODS: periods_r = cfg_data;
                    REG_OFFSETS: offsets_r = cfg_data;
                    REG_DUTIES:  duties_r  = cfg_data;
                    REG_CYCLE:   cycle_len = cfg_data[CLOCK_W-1:0];
                    default:     ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results++;
                if (expected_reports.size() == 0)
                begin
                    $error("leg report 0x%0h arrived with no step pending", m_axis_tdata);
                    fails++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    for (int leg = 0; leg < LEG_SLOTS; leg++)
                    begin
                        got_swing = m_axis_tdata[leg];
                        got_phase = m_axis_tdata[LEG_SLOTS + leg*PHASE_W +: PHASE_W];
                        if (want.swing[leg])
                            swing_n++;
                        else
                            stance_n++;
                        if (got_swing !== want.swing[leg])
                        begin
                            $error("leg%0d_swing: expected %0d, actual %0d",
                                   leg, want.swing[leg], got_swing);
                            fails++;
                        end
                        if (got_phase !== want.phase[leg])
                        begin
                            $error("leg%0d_phase: expected %0d, actual %0d",
                                   leg, want.phase[leg], got_phase);
                            fails++;
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_reports = {expected_reports, advance_gait(s_axis_tdata)};
            fail_count     <= fails;
            pending_count  <= expected_reports.size();
            results_seen   <= results;
            stance_reports <= stance_n;
            swing_reports  <= swing_n;
        end
    end

endmodule

@@ bench/gait_phase_scheduler_tb.sv @@
// Top of the gait phase scheduler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module gait_phase_scheduler_tb;

    import gps_pkg::*;

    localparam int LEG_COUNT     = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 210;
    localparam int LONG_HOLD     = 3000;
    localparam int SETTLE_CYCLES = 300;
    localparam int IDLE_LIMIT    = 20000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = REG_PERIODS;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [STEP_W-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  hold_req      = 1'b0;

    int fail_count;
    int pending_count;
    int results_seen;
    int stance_reports;
    int swing_reports;
    int idle_cycles    = 0;
    int items_sent     = 0;
    int settings_count = 0;
    int burst_left     = 0;

    always #1 clk = ~clk;

    gait_phase_scheduler #(
        .LEG_COUNT  (LEG_COUNT),
        .PHASE_BITS (PHASE_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    gait_phase_checker #(
        .LEG_COUNT (LEG_COUNT)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .results_seen   (results_seen),
        .stance_reports (stance_reports),
        .swing_reports  (swing_reports)
    );

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        bit hold_done;
        int rx_mode;
        int seg_left;
        hold_done = 1'b0;
        rx_mode   = 0;
        seg_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    rx_mode  = $urandom_range(0, 3);
                    seg_left = $urandom_range(16, 600);
                end
                seg_left--;
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic push_step(input logic [STEP_W-1:0] step);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= step;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 250);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] periods,
                                  input logic [CFG_DATA_W-1:0] offsets,
                                  input logic [CFG_DATA_W-1:0] duties,
                                  input logic [CLOCK_W-1:0]    cycle);
        cfg_write <= 1'b1;
        cfg_index <= REG_PERIODS;
        cfg_data  <= periods;
        @(posedge clk);
        cfg_index <= REG_OFFSETS;
        cfg_data  <= offsets;
        @(posedge clk);
        cfg_index <= REG_DUTIES;
        cfg_data  <= duties;
        @(posedge clk);
        cfg_index <= REG_CYCLE;
        cfg_data  <= {{(CFG_DATA_W-CLOCK_W){1'b0}}, cycle};
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_count++;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] periods;
        logic [CFG_DATA_W-1:0] offsets;
        logic [CFG_DATA_W-1:0] duties;
        logic [CLOCK_W-1:0]    cycle;
        logic [LANE_W-1:0]     lane;
        logic [STEP_W-1:0]     step;
        int                    max_per;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With everything at reset every period is zero and any nonzero step wraps the clock.
        push_step(16'd0);
        push_step(16'd1);
        push_step(16'hFFFF);
        push_step(16'h8000);
        drain();

        write_settings({16'd0, 16'd1, 16'hFFFF, 16'd1000},
                       {16'h1234, 16'h8000, 16'd0, 16'hFFFF},
                       {16'h4000, 16'h8000, 16'hFFFF, 16'd0},
                       32'd3000);
        push_step(16'd0);
        push_step(16'd1);
        push_step(16'd250);
        push_step(16'd250);
        push_step(16'd250);
        push_step(16'd250);
        push_step(16'd999);
        push_step(16'd1000);
        push_step(16'hFFFF);
        push_step(16'd2999);
        push_step(16'd1);
        push_step(16'd500);
        drain();

        write_settings('1, '1, '1, '1);
        push_step(16'hFFFF);
        push_step(16'hFFFF);
        push_step(16'hFFFF);
        push_step(16'hFFFF);
        push_step(16'd0);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            max_per = 0;
            for (int leg = 0; leg < LEG_SLOTS; leg++)
            begin
                case ($urandom_range(0, 9))
                    0:       lane = 16'd0;
                    1:       lane = 16'd1;
                    2:       lane = 16'hFFFF;
                    3, 4:    lane = LANE_W'($urandom_range(0, 16'hFFFF));
                    default: lane = LANE_W'($urandom_range(2, 2000));
                endcase
                periods[LANE_W*leg +: LANE_W] = lane;
                if (int'(lane) > max_per)
                    max_per = int'(lane);
                case ($urandom_range(0, 7))
                    0:       lane = 16'd0;
                    1:       lane = 16'hFFFF;
                    2:       lane = 16'h8000;
                    3:       lane = 16'd1;
                    default: lane = LANE_W'($urandom_range(0, 16'hFFFF));
                endcase
                duties[LANE_W*leg +: LANE_W] = lane;
                case ($urandom_range(0, 5))
                    0:       lane = 16'd0;
                    1:       lane = 16'hFFFF;
                    default: lane = LANE_W'($urandom_range(0, 16'hFFFF));
                endcase
                offsets[LANE_W*leg +: LANE_W] = lane;
            end
            case ($urandom_range(0, 7))
                0:       cycle = '0;
                1:       cycle = '1;
                2:       cycle = $urandom;
                3:       cycle = $urandom_range(0, 5000);
                default: cycle = CLOCK_W'(2 * max_per + int'($urandom_range(0, 3)));
            endcase
            write_settings(periods, offsets, duties, cycle);
            if (ph == 2)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 15))
                    0:       step = 16'd0;
                    1:       step = 16'd1;
                    2:       step = 16'hFFFF;
                    3, 4, 5: step = STEP_W'($urandom_range(0, 16'hFFFF));
                    default: step = STEP_W'($urandom_range(1, max_per / 8 + 1));
                endcase
                push_step(step);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("summary: %0d steps under %0d register settings, %0d leg reports checked",
                 items_sent, settings_count, results_seen);
        $display("summary: per-leg outcomes seen: %0d stance, %0d swing",
                 stance_reports, swing_reports);
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
